@@ rtl/ddlc_pkg.sv @@
// ----------------------------------------------------------------------------
// ddlc_pkg
// Shared types and constants for the disruption latency calculator.
// ----------------------------------------------------------------------------
package ddlc_pkg;

    localparam int LAT_W    = 24;
    localparam int STAT_W   = 2;
    localparam int LANES    = 4;
    localparam int CYC_W    = 24;

    // memory type register codes
    localparam logic [1:0] TYPE_LPDDR4 = 2'd0;
    localparam logic [1:0] TYPE_LPDDR5 = 2'd1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO_CLK = 2'd2;

    // lane order: SMMU, HUM, expired ISO (all DRAM clock), RING0 (MC clock)
    localparam int LANE_RING0 = 3;

    // cycle counts already scaled to ns*MHz (cycles * 1000)
    localparam logic [CYC_W-1:0] CYC_LP4 [LANES] =
        '{24'd6003000, 24'd1247000, 24'd424000, 24'd63000};
    localparam logic [CYC_W-1:0] CYC_LP5 [LANES] =
        '{24'd9005000, 24'd4768000, 24'd792000, 24'd63000};

    // hum + iso offsets, refresh, training and calibration, summed
    localparam logic [LAT_W-1:0] FIXED_LP4 = 24'd2271;
    localparam logic [LAT_W-1:0] FIXED_LP5 = 24'd2622;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              lp5;
    } ddlc_side_t;

endpackage

@@ rtl/ddlc_div_pipe.sv @@
// ----------------------------------------------------------------------------
// ddlc_div_pipe
// Four-lane restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ddlc_div_pipe #(
    parameter int FREQ_BITS = 14,
    parameter int NW        = 25
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 adv,
    input  logic                                 in_valid,
    input  ddlc_pkg::ddlc_side_t                 in_side,
    input  logic [ddlc_pkg::LANES-1:0][NW-1:0]   in_num,
    input  logic [ddlc_pkg::LANES-1:0][FREQ_BITS-1:0] in_den,
    output logic                                 out_valid,
    output ddlc_pkg::ddlc_side_t                 out_side,
    output logic [ddlc_pkg::LANES-1:0][NW-1:0]   out_quo
);
    import ddlc_pkg::*;

    logic                                 vld_reg  [NW];
    ddlc_side_t                           side_reg [NW];
    logic [LANES-1:0][FREQ_BITS-1:0]      rem_reg  [NW];
    logic [LANES-1:0][NW-1:0]             nq_reg   [NW];
    logic [LANES-1:0][FREQ_BITS-1:0]      den_reg  [NW];
    logic [LANES-1:0][FREQ_BITS-1:0]      rem_next [NW];
    logic [LANES-1:0][NW-1:0]             nq_next  [NW];

    for (genvar s = 0; s < NW; s++) begin : g_stage
        for (genvar k = 0; k < LANES; k++) begin : g_lane
            logic [FREQ_BITS-1:0] rem_src;
            logic [NW-1:0]        nq_src;
            logic [FREQ_BITS-1:0] den_src;
            logic [FREQ_BITS:0]   trial;
            logic                 ge;
            if (s == 0) begin : g_first
                assign rem_src = '0;
                assign nq_src  = in_num[k];
                assign den_src = in_den[k];
            end else begin : g_next
                assign rem_src = rem_reg[s-1][k];
                assign nq_src  = nq_reg[s-1][k];
                assign den_src = den_reg[s-1][k];
            end
            // shift in the next numerator bit, subtract when it fits
            assign trial = {rem_src, nq_src[NW-1]};
            assign ge    = trial >= {1'b0, den_src};
            assign rem_next[s][k] = ge ? FREQ_BITS'(trial - {1'b0, den_src})
                                       : trial[FREQ_BITS-1:0];
            assign nq_next[s][k]  = {nq_src[NW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (adv) begin
                vld_reg[s] <= (s == 0) ? in_valid : vld_reg[(s == 0) ? 0 : s-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg[s] <= (s == 0) ? in_side : side_reg[(s == 0) ? 0 : s-1];
                den_reg[s]  <= (s == 0) ? in_den  : den_reg[(s == 0) ? 0 : s-1];
                rem_reg[s]  <= rem_next[s];
                nq_reg[s]   <= nq_next[s];
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign out_side  = side_reg[NW-1];
    assign out_quo   = nq_reg[NW-1];

endmodule

@@ rtl/dram_disruption_latency_calc_unit.sv @@
// ----------------------------------------------------------------------------
// dram_disruption_latency_calc_unit
// Worst-case DRAM bandwidth disruption time, in ns, from the DRAM and MC clock frequencies.
// ----------------------------------------------------------------------------
// Path: front-stage register, then the one-bit-per-stage divider pipeline
//   (NW = 25 at FREQ_BITS up to 24), then the result register.
// Throughput: one beat per cycle; the whole pipeline holds while the result
//   register is full and not taken.
// Reset: aresetn synchronous, active low; clears all valid bits and sets
//   the memory type to LPDDR4.
module dram_disruption_latency_calc_unit #(
    parameter int FREQ_BITS = 14
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: memory type
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [((2*FREQ_BITS+7)/8)*8-1:0] s_tdata, // ddr_mhz, mc_freq
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata                      // latency_ns, status
);
    import ddlc_pkg::*;

    // numerator carries cycles*1000 + den - 1, so it is one bit above both
    localparam int NW = ((FREQ_BITS > CYC_W) ? FREQ_BITS : CYC_W) + 1;

    logic [1:0]                        mem_kind_reg;
    logic                              adv;
    logic [FREQ_BITS-1:0]              ddr_mhz, mc_freq;

    logic                              v0_reg;
    ddlc_side_t                        side0_reg;
    logic [LANES-1:0][NW-1:0]          num0_reg;
    logic [LANES-1:0][FREQ_BITS-1:0]   den0_reg;
    ddlc_side_t                        side0_next;
    logic [LANES-1:0][NW-1:0]          num0_next;
    logic [LANES-1:0][FREQ_BITS-1:0]   den0_next;

    logic                              dv;
    ddlc_side_t                        dside;
    logic [LANES-1:0][NW-1:0]          dquo;

    logic [LAT_W+1:0]                  sum;
    logic                              m_tvalid_reg;
    logic [LAT_W-1:0]                  lat_reg;
    logic [STAT_W-1:0]                 stat_reg;

    // advance everything when the result register is free or being taken
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    assign ddr_mhz = s_tdata[FREQ_BITS-1:0];
    assign mc_freq = s_tdata[2*FREQ_BITS-1:FREQ_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_kind_reg <= TYPE_LPDDR4;
        end else if (cfg_we) begin
            mem_kind_reg <= cfg_wdata;
        end
    end

    // front stage: classify, pick constants, form rounded-up numerators
    always_comb begin
        side0_next.lp5 = (mem_kind_reg == TYPE_LPDDR5);
        if (mem_kind_reg != TYPE_LPDDR4 && mem_kind_reg != TYPE_LPDDR5) begin
            side0_next.status = ST_BAD_TYPE;
        end else if (ddr_mhz == '0 || mc_freq == '0) begin
            side0_next.status = ST_ZERO_CLK;
        end else begin
            side0_next.status = ST_OK;
        end
        for (int k = 0; k < LANES; k++) begin
            den0_next[k] = (k == LANE_RING0) ? mc_freq : ddr_mhz;
            num0_next[k] = NW'(side0_next.lp5 ? CYC_LP5[k] : CYC_LP4[k])
                         + NW'(den0_next[k]) - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side0_reg <= side0_next;
            num0_reg  <= num0_next;
            den0_reg  <= den0_next;
        end
    end

    ddlc_div_pipe #(
        .FREQ_BITS (FREQ_BITS),
        .NW        (NW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v0_reg),
        .in_side   (side0_reg),
        .in_num    (num0_reg),
        .in_den    (den0_reg),
        .out_valid (dv),
        .out_side  (dside),
        .out_quo   (dquo)
    );

    // add the four terms and the fixed offsets; wraps to 24 bits
    assign sum = (LAT_W+2)'(dquo[0][LAT_W-1:0]) + (LAT_W+2)'(dquo[1][LAT_W-1:0])
               + (LAT_W+2)'(dquo[2][LAT_W-1:0]) + (LAT_W+2)'(dquo[3][LAT_W-1:0])
               + (LAT_W+2)'(dside.lp5 ? FIXED_LP5 : FIXED_LP4);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= dv;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stat_reg <= dside.status;
            lat_reg  <= (dside.status == ST_OK) ? sum[LAT_W-1:0] : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(32-LAT_W-STAT_W){1'b0}}, stat_reg, lat_reg};

    // an error result always carries zero latency
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[25:24] != ST_OK) |-> (m_tdata[23:0] == '0))
        else $error("error result with nonzero latency");

    // status code three is never produced
    a_stat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[25:24] != 2'd3))
        else $error("bad status code");

    // a held result freezes the whole pipeline, input included
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result held");

    // a divider result accepted while the pipeline advances becomes a valid result
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && dv |=> m_tvalid)
        else $error("result lost at output register");

endmodule
